// ----- src/assert_macros.svh -----
// Assertion macros shared by the checker files of this project.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/mtc_pkg.sv -----
// Shared types, constants and helpers for the monotonic timebase converter.
// No dependencies; every other file of the block imports this package.
package mtc_pkg;

  localparam int SEC_W   = 32;  // width of the kept seconds counter
  localparam int NS_W    = 30;
  localparam int QCNT_W  = 32;
  localparam int ISEC_W  = 31;
  localparam int DIV_W   = 61;  // holds 31 x 30 bit products and sec * 1e9 + nsec
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  localparam logic [NS_W-1:0]   NS_PER_SEC = 30'd1000000000;
  localparam logic [NS_W-1:0]   MAX_NS     = 30'd999999999;
  localparam logic [NS_W-1:0]   QLEN_RESET = 30'd1000000;
  localparam logic [QCNT_W-1:0] QUANTA_MAX = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_TICK        = 2'd0,
    CMD_READ        = 2'd1,
    CMD_TO_QUANTA   = 2'd2,
    CMD_TO_INTERVAL = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              command;
    logic [NS_W-1:0]   elapsed_ns;
    logic [ISEC_W-1:0] interval_sec;
    logic [NS_W-1:0]   interval_nsec;
    logic              round_away;
    logic [ISEC_W-1:0] quanta_in;
  } mtc_in_t;

  typedef struct packed {
    logic [31:0]       out_sec;
    logic [NS_W-1:0]   out_nsec;
    logic [QCNT_W-1:0] out_quanta;
    logic              saturated;
  } mtc_out_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [NS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [NS_W-1:0]  remainder;
  } div_rsp_t;

  // Clamp the programmed quantum length into 1 .. 999999999 ns.
  function automatic logic [NS_W-1:0] eff_quantum(input logic [NS_W-1:0] len);
    logic [NS_W-1:0] q;
    q = len;
    if (len == '0) begin
      q = NS_W'(1);
    end else if (len > MAX_NS) begin
      q = MAX_NS;
    end
    return q;
  endfunction

endpackage

// ----- src/monotonic_timebase_converter_unit.sv -----
// Top level of the monotonic timebase converter: time keeping, sequencer and multiplier.
// Depends on mtc_pkg and the shared divider mtc_div.
//
// Usage:
//   Command channel: drive in_data and raise start; the command transfers at the
//   rising edge where start is high and busy is low.
//   Result channel: every command yields one result, shown on out_data for exactly
//   one cycle with out_valid high. The receiver cannot stall; capture it then.
//   Config channel: cfg_data carries the quantum length in ns and transfers when
//   cfg_valid and cfg_ready are both high. cfg_ready is high when busy and start are low.
// Timing:
//   Tick and read: out_valid rises the cycle after the transfer and busy
//   stays low, so these commands may follow every cycle.
//   Interval-to-quanta and quanta-to-interval run one 31x30 multiply, one add,
//   then 61 steps of the bit-serial divider; busy is high from the transfer
//   until the result appears, so the next command waits for the conversion.
// Reset:
//   Synchronous, active low. Clears time, quantum count and sequencer; the quantum
//   length returns to 1000000 ns.
module monotonic_timebase_converter_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  mtc_pkg::mtc_in_t in_data,
  output logic             out_valid,
  output mtc_pkg::mtc_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [29:0]      cfg_data
);
  import mtc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_LOAD = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NS_W-1:0]   qlen_r, qlen_nxt;
  logic [SEC_W-1:0]  tsec_r, tsec_nxt;
  logic [NS_W-1:0]   tns_r, tns_nxt;
  logic [QCNT_W-1:0] qcnt_r, qcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  mtc_out_t          out_r, out_nxt;
  mtc_in_t           in_r, in_nxt;
  logic [DIV_W-1:0]  mul_r, mul_nxt;

  logic [NS_W-1:0]   q_eff;
  logic [NS_W-1:0]   el_clamp;
  logic [NS_W-1:0]   ns_addend;
  logic [NS_W:0]     ns_sum;
  logic              ns_carry;
  logic [NS_W-1:0]   ns_wrapped;
  logic [ISEC_W-1:0] mul_a;
  logic [NS_W-1:0]   mul_b;
  logic [DIV_W-1:0]  qn_round;
  logic              qn_sat;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  assign q_eff    = eff_quantum(qlen_r);
  assign el_clamp = (in_data.elapsed_ns > MAX_NS) ? MAX_NS : in_data.elapsed_ns;

  // Single nanosecond adder: tick adds the quantum, read adds the elapsed time.
  assign ns_addend  = (in_data.command == CMD_TICK) ? q_eff : el_clamp;
  assign ns_sum     = {1'b0, tns_r} + {1'b0, ns_addend};
  assign ns_carry   = ns_sum >= {1'b0, NS_PER_SEC};
  assign ns_wrapped = ns_carry ? NS_W'(ns_sum - {1'b0, NS_PER_SEC}) : ns_sum[NS_W-1:0];

  // Multiplier operands: seconds times one billion, or quanta times quantum length.
  assign mul_a = (in_r.command == CMD_TO_QUANTA) ? in_r.interval_sec : in_r.quanta_in;
  assign mul_b = (in_r.command == CMD_TO_QUANTA) ? NS_PER_SEC : q_eff;

  // Round up when asked and the division left a remainder; clamp to 31 bits.
  assign qn_round = div_rsp.quotient
                  + DIV_W'(in_r.round_away && (div_rsp.remainder != '0));
  assign qn_sat   = qn_round > DIV_W'(QUANTA_MAX);

  always_comb begin
    state_nxt        = state_r;
    qlen_nxt         = qlen_r;
    tsec_nxt         = tsec_r;
    tns_nxt          = tns_r;
    qcnt_nxt         = qcnt_r;
    out_valid_nxt    = 1'b0;
    out_nxt          = out_r;
    in_nxt           = in_r;
    mul_nxt          = mul_r;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;

    if (cfg_valid && cfg_ready) begin
      qlen_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt = in_data;
          unique case (in_data.command)
            CMD_TICK: begin
              // advance time by one quantum, carry at most once
              tns_nxt  = ns_wrapped;
              tsec_nxt = tsec_r + SEC_W'(ns_carry);
              qcnt_nxt = qcnt_r + QCNT_W'(1);
              out_nxt.out_sec    = 32'(tsec_nxt);
              out_nxt.out_nsec   = ns_wrapped;
              out_nxt.out_quanta = qcnt_nxt;
              out_nxt.saturated  = 1'b0;
              out_valid_nxt      = 1'b1;
            end
            CMD_READ: begin
              out_nxt.out_sec    = 32'(tsec_r + SEC_W'(ns_carry));
              out_nxt.out_nsec   = ns_wrapped;
              out_nxt.out_quanta = qcnt_r;
              out_nxt.saturated  = 1'b0;
              out_valid_nxt      = 1'b1;
            end
            CMD_TO_QUANTA, CMD_TO_INTERVAL: begin
              state_nxt = S_MUL;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_MUL: begin
        mul_nxt   = {{(DIV_W-ISEC_W){1'b0}}, mul_a} * {{(DIV_W-NS_W){1'b0}}, mul_b};
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // add the nanosecond part for interval-to-quanta and hand the total to the divider
        div_req.start    = 1'b1;
        div_req.dividend = mul_r + ((in_r.command == CMD_TO_QUANTA) ?
                                    DIV_W'(in_r.interval_nsec) : '0);
        div_req.divisor  = (in_r.command == CMD_TO_QUANTA) ? q_eff : NS_PER_SEC;
        state_nxt        = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (in_r.command == CMD_TO_QUANTA) begin
            out_nxt.out_sec    = '0;
            out_nxt.out_nsec   = '0;
            out_nxt.out_quanta = qn_sat ? QUANTA_MAX : qn_round[QCNT_W-1:0];
            out_nxt.saturated  = qn_sat;
          end else begin
            out_nxt.out_sec    = 32'(SEC_W'(div_rsp.quotient));
            out_nxt.out_nsec   = div_rsp.remainder;
            out_nxt.out_quanta = '0;
            out_nxt.saturated  = 1'b0;
          end
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qlen_r      <= QLEN_RESET;
      tsec_r      <= '0;
      tns_r       <= '0;
      qcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qlen_r      <= qlen_nxt;
      tsec_r      <= tsec_nxt;
      tns_r       <= tns_nxt;
      qcnt_r      <= qcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    in_r  <= in_nxt;
    mul_r <= mul_nxt;
  end

  mtc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Hold off a quantum-length write while a command is offered, so the two
  // never transfer on the same edge.
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/mtc_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on mtc_pkg for widths and the request/response structs.
module mtc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mtc_pkg::div_req_t req,
  output mtc_pkg::div_rsp_t rsp
);
  import mtc_pkg::*;

  logic [DIV_W-1:0]  acc_r, acc_nxt;
  logic [NS_W-1:0]   rem_r, rem_nxt;
  logic [NS_W-1:0]   dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [NS_W:0]     trial;
  logic              fits;

  assign trial = {rem_r, acc_r[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = DCNT_W'(DIV_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift in the next dividend bit, subtract when the divisor fits
      rem_nxt = fits ? NS_W'(trial - {1'b0, dvs_r}) : trial[NS_W-1:0];
      acc_nxt = {acc_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = acc_r;
  assign rsp.remainder = rem_r;

endmodule

// ----- src/mtc_chk.sv -----
// Port-level checker for the monotonic timebase converter, bound to the top level.
// Depends on mtc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mtc_chk (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  mtc_pkg::mtc_in_t  in_data,
  input  logic              out_valid,
  input  mtc_pkg::mtc_out_t out_data
);
  import mtc_pkg::*;

  logic fast_cmd;
  logic fast_xfer;
  logic conv_xfer;
  logic sat_shown;

  assign fast_cmd  = (in_data.command == CMD_TICK) || (in_data.command == CMD_READ);
  assign fast_xfer = start && !busy && fast_cmd;
  assign conv_xfer = start && !busy && !fast_cmd;
  assign sat_shown = out_valid && out_data.saturated;

  `ASSERT_CLK(a_fast_cmd_result, fast_xfer |=> out_valid, "tick or read gave no result")
  `ASSERT_CLK(a_conv_goes_busy, conv_xfer |=> busy, "conversion did not raise busy")
  `ASSERT_CLK(a_busy_end_result, $fell(busy) |-> out_valid, "busy dropped without a result")
  `ASSERT_CLK(a_sat_clamped, sat_shown |-> (out_data.out_quanta == QUANTA_MAX), "not clamped")

endmodule

bind monotonic_timebase_converter_unit mtc_chk u_mtc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// ----- test/mtc_checker.sv -----
// Checker for the monotonic timebase converter: watches the command, result and
// quantum-length channels, predicts each result and compares it field by field.
// Depends on mtc_pkg for the channel types and command codes.
`timescale 1ns / 100ps

module mtc_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  mtc_pkg::mtc_in_t  in_data,
  input  logic              out_valid,
  input  mtc_pkg::mtc_out_t out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [29:0]       cfg_data,
  output int                fail_count,
  output int                pending
);
  import mtc_pkg::*;

  localparam longint unsigned NS_PER_SECOND   = 64'd1_000_000_000;
  localparam longint unsigned LONGEST_QUANTUM = 64'd999_999_999;
  localparam longint unsigned QUANTA_LIMIT    = 64'd2_147_483_647;
  localparam logic [29:0]     QUANTUM_AT_RESET = 30'd1_000_000;

  logic [29:0] quantum_len;
  logic [31:0] clock_sec;
  logic [29:0] clock_nsec;
  logic [31:0] tick_count;
  mtc_out_t    expected_results[$];
  int          mismatches;

  // Work out the result of one command; a tick also advances the kept time.
  function automatic mtc_out_t timebase_result(input mtc_in_t c);
    mtc_out_t          r;
    longint unsigned   q;
    longint unsigned   nsum;
    longint unsigned   el;
    longint unsigned   total;
    longint unsigned   quanta;
    longint unsigned   prod;
    logic [31:0]       sec;
    r = '0;
    q = 64'(quantum_len);
    if (q == 64'd0) begin
      q = 64'd1;
    end else if (q > LONGEST_QUANTUM) begin
      q = LONGEST_QUANTUM;
    end
    case (c.command)
      CMD_TICK: begin
        tick_count = tick_count + 32'd1;
        nsum = 64'(clock_nsec) + q;
        if (nsum >= NS_PER_SECOND) begin
          nsum = nsum - NS_PER_SECOND;
          clock_sec = clock_sec + 32'd1;
        end
        clock_nsec = nsum[29:0];
        r.out_sec = clock_sec;
        r.out_nsec = clock_nsec;
        r.out_quanta = tick_count;
      end
      CMD_READ: begin
        el = 64'(c.elapsed_ns);
        if (el > LONGEST_QUANTUM) begin
          el = LONGEST_QUANTUM;
        end
        sec = clock_sec;
        nsum = 64'(clock_nsec) + el;
        if (nsum >= NS_PER_SECOND) begin
          nsum = nsum - NS_PER_SECOND;
          sec = sec + 32'd1;
        end
        r.out_sec = sec;
        r.out_nsec = nsum[29:0];
        r.out_quanta = tick_count;
      end
      CMD_TO_QUANTA: begin
        total = 64'(c.interval_sec) * NS_PER_SECOND + 64'(c.interval_nsec);
        quanta = total / q;
        if (c.round_away && quanta * q < total) begin
          quanta = quanta + 64'd1;
        end
        if (quanta > QUANTA_LIMIT) begin
          quanta = QUANTA_LIMIT;
          r.saturated = 1'b1;
        end
        r.out_quanta = quanta[31:0];
      end
      default: begin
        prod = 64'(c.quanta_in) * q;
        r.out_sec = 32'(prod / NS_PER_SECOND);
        r.out_nsec = 30'(prod % NS_PER_SECOND);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    mtc_out_t want;
    if (!rst_n) begin
      quantum_len = QUANTUM_AT_RESET;
      clock_sec = '0;
      clock_nsec = '0;
      tick_count = '0;
      expected_results.delete();
    end else begin
      // Check the result first: it belongs to an earlier command transfer.
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_sec !== want.out_sec) begin
            $error("out_sec: expected %0d, got %0d", want.out_sec, out_data.out_sec);
            mismatches++;
          end
          if (out_data.out_nsec !== want.out_nsec) begin
            $error("out_nsec: expected %0d, got %0d", want.out_nsec, out_data.out_nsec);
            mismatches++;
          end
          if (out_data.out_quanta !== want.out_quanta) begin
            $error("out_quanta: expected %0d, got %0d", want.out_quanta,
                   out_data.out_quanta);
            mismatches++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated,
                   out_data.saturated);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(timebase_result(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        quantum_len = cfg_data;
      end
    end
    fail_count <= mismatches;
    pending <= expected_results.size();
  end

endmodule

// ----- test/testbench.sv -----
// Top of the monotonic timebase converter testbench: clock, reset, command and
// quantum-length stimulus, timeout and verdict.
// Depends on mtc_pkg, the block monotonic_timebase_converter_unit and mtc_checker.
`timescale 1ns / 100ps

module testbench;
  import mtc_pkg::*;

  // Allow a margin for a conversion in flight before reprogramming or ending.
  localparam int SETTLE_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 172;
  localparam int PHASES = 8;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  mtc_in_t     in_data = '0;
  logic        out_valid;
  mtc_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [29:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          idle_pct = 11;

  monotonic_timebase_converter_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  mtc_checker timebase_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Hold start low for a random gap, then present one command and hold it
  // until it transfers. Start is left high so the next command can follow
  // back to back; callers drop it when they stop issuing.
  task automatic issue(input cmd_t cmd, input logic [29:0] elapsed,
                       input logic [30:0] isec, input logic [29:0] insec,
                       input logic round_up, input logic [30:0] quanta);
    mtc_in_t item;
    item.command = cmd;
    item.elapsed_ns = elapsed;
    item.interval_sec = isec;
    item.interval_nsec = insec;
    item.round_away = round_up;
    item.quanta_in = quanta;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= item;
    // busy read here is its value before the edge, so a low value means transfer.
    do @(posedge clk); while (busy);
  endtask

  // Drop start, let every outstanding result drain, then wait out any
  // conversion still in flight.
  task automatic drain;
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Program the quantum length while the block is idle.
  task automatic write_quantum(input logic [29:0] len);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [29:0] quantum_settings[PHASES];
    quantum_settings = '{30'd1, 30'd999_999_999, 30'd0, 30'h3FFF_FFFF,
                         30'd1_000_000_000, 30'd0, 30'd1_000_000, 30'd500_000_000};
    quantum_settings[5] = 30'($urandom_range(999_999_999, 1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands at the reset quantum length of one millisecond.
    issue(CMD_READ, 30'd0, '0, '0, 1'b0, '0);
    issue(CMD_READ, 30'd999_999_999, '0, '0, 1'b0, '0);
    // Elapsed above one billion clamps to the largest valid value.
    issue(CMD_READ, 30'h3FFF_FFFF, '0, '0, 1'b0, '0);
    issue(CMD_TICK, '0, '0, '0, 1'b0, '0);
    // Read that carries into seconds.
    issue(CMD_READ, 30'd999_999_999, '0, '0, 1'b0, '0);
    issue(CMD_TICK, 30'h3FFF_FFFF, 31'h7FFF_FFFF, 30'h3FFF_FFFF, 1'b1, 31'h7FFF_FFFF);
    issue(CMD_TO_QUANTA, '0, 31'd0, 30'd0, 1'b0, '0);
    issue(CMD_TO_QUANTA, '0, 31'd0, 30'd1, 1'b0, '0);
    issue(CMD_TO_QUANTA, '0, 31'd0, 30'd1, 1'b1, '0);
    issue(CMD_TO_QUANTA, '0, 31'd2, 30'd500_000, 1'b0, '0);
    issue(CMD_TO_QUANTA, '0, 31'd2, 30'd500_000, 1'b1, '0);
    // Largest interval saturates the quanta.
    issue(CMD_TO_QUANTA, 30'h3FFF_FFFF, 31'h7FFF_FFFF, 30'h3FFF_FFFF, 1'b1, 31'h7FFF_FFFF);
    // Nanoseconds above one billion are added as they stand.
    issue(CMD_TO_QUANTA, '0, 31'd0, 30'h3FFF_FFFF, 1'b0, '0);
    // Exactly the largest count, then one past it only through rounding up.
    issue(CMD_TO_QUANTA, '0, 31'd2_147_483, 30'd647_000_000, 1'b0, '0);
    issue(CMD_TO_QUANTA, '0, 31'd2_147_483, 30'd647_000_001, 1'b0, '0);
    issue(CMD_TO_QUANTA, '0, 31'd2_147_483, 30'd647_000_001, 1'b1, '0);
    issue(CMD_TO_INTERVAL, '0, '0, '0, 1'b0, 31'd0);
    issue(CMD_TO_INTERVAL, '0, '0, '0, 1'b0, 31'd1);
    issue(CMD_TO_INTERVAL, 30'h3FFF_FFFF, 31'h7FFF_FFFF, 30'h3FFF_FFFF, 1'b1,
          31'h7FFF_FFFF);
    issue(CMD_READ, 30'h3FFF_FFFF, 31'h7FFF_FFFF, 30'h3FFF_FFFF, 1'b1, 31'h7FFF_FFFF);

    // Random phases, each under its own quantum length; sender gaps at 11 %,
    // then 49 %, then none.
    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct = (ph < 3) ? 11 : (ph < 6) ? 49 : 0;
      write_quantum(quantum_settings[ph]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Mix smaller magnitudes with full-width ones.
        issue(cmd_t'($urandom_range(3)),
              $urandom_range(1) ? 30'($urandom) : 30'($urandom_range(999_999_999, 990_000_000)),
              $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(4000)),
              30'($urandom),
              1'($urandom_range(1)),
              $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(5000)));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Stop a hung run; well above the slowest correct run.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- monotonic_timebase_converter_unit.f -----
+incdir+src
src/mtc_pkg.sv
src/mtc_div.sv
src/monotonic_timebase_converter_unit.sv
src/mtc_chk.sv
test/mtc_checker.sv
test/testbench.sv
